[hdl/sces_pkg.sv]
// Shared types and constants of the scan-line chroma edge segmenter.
package sces_pkg;

  // Kernel length and field widths
  localparam int unsigned TapsC     = 5;
  localparam int unsigned CoordBits = 10;
  localparam int unsigned RespBits  = 13;
  localparam int unsigned DiffBits  = 9;
  localparam int unsigned FillBits  = 3;
  localparam int unsigned LineBits  = 3;

  localparam logic [FillBits-1:0] FillFull = FillBits'(TapsC);

  // Configuration register indexes
  localparam logic CfgGradThr  = 1'b0;
  localparam logic CfgMinLuma  = 1'b1;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
  } pos_t;

  // One closed segment
  typedef struct packed {
    logic [LineBits-1:0]        seg_line;
    pos_t                       begin_pos;
    pos_t                       end_pos;
    pos_t                       mid_pos;
    logic signed [RespBits-1:0] begin_response;
    logic signed [DiffBits-1:0] begin_diff;
    logic signed [RespBits-1:0] end_response;
    logic signed [DiffBits-1:0] end_diff;
    logic                       maybe_obstacle;
  } seg_t;

endpackage

[hdl/scanline_chroma_edge_segmenter_unit.sv]
// Top level of the scan-line chroma edge segmenter.
//
// Takes one YUV pixel per transfer on the slave stream and filters V - U
// with a 1,2,4,2,1 kernel centred two pixels back. A run opens when the
// weighted sum reaches ten times gradient_threshold and the centre luma
// reaches min_luma; when it closes, one segment goes out on the master
// stream. A line start (tuser) clears the history and drops an open run;
// nothing is evaluated until five pixels of the line are in. One pixel is
// taken every cycle: the filter, the compare and the run state update are
// combinational between the history registers and the output register,
// and a one-entry skid register holds a segment while the output is
// stalled, so input stops only when both are full. A segment is registered
// in the output register, or in the skid register while the output stalls.
module scanline_chroma_edge_segmenter_unit
  import sces_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [7:0]   cfg_wdata_i,
  // pixel stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // luma[7:0], chroma_u[15:8], chroma_v[23:16], pos_x[33:24],
  // pos_y[43:34], line_index[46:44], zero fill[47]
  input  logic [47:0]  s_axis_tdata_i,
  // line_start[0]
  input  logic [0:0]   s_axis_tuser_i,
  // segment stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // seg_line[2:0], begin_x[12:3], begin_y[22:13], end_x[32:23],
  // end_y[42:33], mid_x[52:43], mid_y[62:53], begin_response[75:63],
  // begin_diff[84:76], end_response[97:85], end_diff[106:98],
  // zero fill[111:107]
  output logic [111:0] m_axis_tdata_o,
  // maybe_obstacle[0]
  output logic [0:0]   m_axis_tuser_o
);

  // Configuration registers
  logic [7:0] grad_thr_q;
  logic [7:0] min_luma_q;

  // Line history: newest entry at index 0
  logic signed [DiffBits-1:0] diff_hist_q [TapsC-1];
  logic [7:0]                 luma_hist_q [2];
  pos_t                       pos_hist_q  [2];
  logic [FillBits-1:0]        fill_q;
  logic                       in_run_q;
  logic                       run_obst_q;
  pos_t                       run_pos_q;
  logic signed [RespBits-1:0] run_resp_q;
  logic signed [DiffBits-1:0] run_diff_q;

  // Output and skid registers
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  seg_t out_q, out_d;
  seg_t skid_q, skid_d;

  // Unpacked input fields
  logic [7:0]          in_luma, in_u, in_v;
  pos_t                in_pos;
  logic [LineBits-1:0] in_line;
  logic                in_start;
  logic                accept;

  assign in_luma  = s_axis_tdata_i[7:0];
  assign in_u     = s_axis_tdata_i[15:8];
  assign in_v     = s_axis_tdata_i[23:16];
  assign in_pos.x = s_axis_tdata_i[33:24];
  assign in_pos.y = s_axis_tdata_i[43:34];
  assign in_line  = s_axis_tdata_i[46:44];
  assign in_start = s_axis_tuser_i[0];

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Apply the line start before the pixel is taken in
  logic signed [DiffBits-1:0] h0, h1, h2, h3;
  logic [7:0]                 centre_luma;
  pos_t                       centre_pos;
  logic [FillBits-1:0]        fill_eff, fill_new;
  logic                       in_run_eff, obst_eff;

  assign h0          = in_start ? '0 : diff_hist_q[0];
  assign h1          = in_start ? '0 : diff_hist_q[1];
  assign h2          = in_start ? '0 : diff_hist_q[2];
  assign h3          = in_start ? '0 : diff_hist_q[3];
  assign centre_luma = in_start ? '0 : luma_hist_q[1];
  assign centre_pos  = in_start ? '0 : pos_hist_q[1];
  assign fill_eff    = in_start ? '0 : fill_q;
  assign in_run_eff  = in_start ? 1'b0 : in_run_q;
  assign obst_eff    = in_start ? 1'b0 : run_obst_q;
  assign fill_new    = (fill_eff < FillFull) ? fill_eff + 1'b1 : fill_eff;

  // Filter the difference with 1,2,4,2,1
  logic signed [DiffBits-1:0] diff;
  logic signed [RespBits-1:0] sum;
  logic [11:0]                thr10;
  logic                       eval, hit, run_open, run_close;

  assign diff = $signed({1'b0, in_v}) - $signed({1'b0, in_u});
  assign sum  = $signed({{4{diff[8]}}, diff})
              + $signed({{3{h0[8]}}, h0, 1'b0})
              + $signed({{2{h1[8]}}, h1, 2'b00})
              + $signed({{3{h2[8]}}, h2, 1'b0})
              + $signed({{4{h3[8]}}, h3});
  assign thr10 = {1'b0, grad_thr_q, 3'b000} + {3'b000, grad_thr_q, 1'b0};

  assign eval      = (fill_new == FillFull);
  assign hit       = (sum >= $signed({1'b0, thr10})) && (centre_luma >= min_luma_q);
  assign run_open  = accept && eval && hit && !in_run_eff;
  assign run_close = accept && eval && !hit && in_run_eff;

  // Build the closed segment
  seg_t                 seg;
  logic [CoordBits:0]   mid_sx, mid_sy;

  assign mid_sx = {1'b0, run_pos_q.x} + {1'b0, centre_pos.x};
  assign mid_sy = {1'b0, run_pos_q.y} + {1'b0, centre_pos.y};

  always_comb begin
    seg.seg_line       = in_line;
    seg.begin_pos      = run_pos_q;
    seg.end_pos        = centre_pos;
    seg.mid_pos.x      = mid_sx[CoordBits:1];
    seg.mid_pos.y      = mid_sy[CoordBits:1];
    seg.begin_response = run_resp_q;
    seg.begin_diff     = run_diff_q;
    seg.end_response   = sum;
    seg.end_diff       = diff;
    seg.maybe_obstacle = obst_eff;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grad_thr_q <= 8'd10;
      min_luma_q <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgGradThr: grad_thr_q <= cfg_wdata_i;
        CfgMinLuma: min_luma_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // Shift the history and track the run on each pixel transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_hist_q <= '{default: '0};
      luma_hist_q <= '{default: '0};
      pos_hist_q  <= '{default: '0};
      fill_q      <= '0;
      in_run_q    <= 1'b0;
      run_obst_q  <= 1'b0;
    end else if (accept) begin
      diff_hist_q[0] <= diff;
      diff_hist_q[1] <= h0;
      diff_hist_q[2] <= h1;
      diff_hist_q[3] <= h2;
      luma_hist_q[0] <= in_luma;
      luma_hist_q[1] <= in_start ? '0 : luma_hist_q[0];
      pos_hist_q[0]  <= in_pos;
      pos_hist_q[1]  <= in_start ? '0 : pos_hist_q[0];
      fill_q         <= fill_new;
      if (run_open) begin
        in_run_q   <= 1'b1;
        run_obst_q <= diff[DiffBits-1];
      end else if (run_close) begin
        in_run_q   <= 1'b0;
        run_obst_q <= 1'b0;
      end else begin
        in_run_q   <= in_run_eff;
        run_obst_q <= obst_eff;
      end
    end
  end

  // Hold the begin of the run
  always_ff @(posedge clk_i) begin
    if (run_open) begin
      run_pos_q  <= centre_pos;
      run_resp_q <= sum;
      run_diff_q <= diff;
    end
  end

  // Output register with skid: drain the skid first, else take new segments
  logic out_take;
  assign out_take = out_valid_q && m_axis_tready_i;

  always_comb begin
    out_valid_d  = out_valid_q && !out_take;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (run_close) begin
      if (!out_valid_q || out_take) begin
        out_valid_d = 1'b1;
        out_d       = seg;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = seg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Pack the segment stream
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000,
                            out_q.end_diff,
                            out_q.end_response,
                            out_q.begin_diff,
                            out_q.begin_response,
                            out_q.mid_pos.y,
                            out_q.mid_pos.x,
                            out_q.end_pos.y,
                            out_q.end_pos.x,
                            out_q.begin_pos.y,
                            out_q.begin_pos.x,
                            out_q.seg_line};
  assign m_axis_tuser_o  = out_q.maybe_obstacle;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a segment while the output register is empty");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled segment changed or vanished");

  a_run_after_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_run_q |-> (fill_q == FillFull))
    else $error("run open before the filter is filled");

  a_close_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_close && !in_start) |-> in_run_q)
    else $error("segment closed without an open run");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the scan-line chroma edge segmenter unit.
`timescale 1ns / 1ps

module testbench;
  import sces_pkg::*;

  // One pixel as it travels on the slave stream
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] u;
    logic [7:0] v;
    logic [9:0] x;
    logic [9:0] y;
    logic       ls;
    logic [2:0] line;
  } pixel_t;

  // One closed segment, field by field
  typedef struct {
    logic [2:0]         line;
    logic [9:0]         bx;
    logic [9:0]         by;
    logic [9:0]         ex;
    logic [9:0]         ey;
    logic [9:0]         mx;
    logic [9:0]         my;
    logic signed [12:0] br;
    logic signed [8:0]  bd;
    logic signed [12:0] er;
    logic signed [8:0]  ed;
    logic               obst;
  } seg_rec_t;

  // How a directed row gets its expectation
  typedef enum {ROW_PREDICT, ROW_NONE, ROW_SEG} row_kind_e;
  // Chroma pattern of a stretch of pixels in a random line
  typedef enum {CHROMA_HIGH, CHROMA_LOW, CHROMA_FLAT, CHROMA_RAND} chroma_mode_e;

  typedef struct {
    pixel_t    px;
    row_kind_e kind;
    seg_rec_t  seg;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_addr_i = CfgGradThr;
  logic [7:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // luma, chroma_u, chroma_v, pos_x, pos_y, line_index, zero fill
  logic [47:0]  s_axis_tdata_i = '0;
  // line_start
  logic [0:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // seg_line, begin_x, begin_y, end_x, end_y, mid_x, mid_y, begin_response,
  // begin_diff, end_response, end_diff, zero fill
  logic [111:0] m_axis_tdata_o;
  // maybe_obstacle
  logic [0:0]   m_axis_tuser_o;

  scanline_chroma_edge_segmenter_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Segmenter state mirrored for prediction, cleared as after reset
  int          chroma_hist[5] = '{default: 0};
  logic [7:0]  luma_hist[3] = '{default: '0};
  logic [9:0]  col_hist[3] = '{default: '0};
  logic [9:0]  row_hist[3] = '{default: '0};
  int          fill_cnt = 0;
  bit          run_open = 1'b0;
  bit          run_neg = 1'b0;
  logic [9:0]  run_bx = '0;
  logic [9:0]  run_by = '0;
  int          run_resp = 0;
  int          run_diff = 0;
  logic [7:0]  cfg_thresh = 8'd10;
  logic [7:0]  cfg_min_luma = 8'd0;

  seg_rec_t    pending_segments[$];
  dir_row_t    dir_rows[$];
  int          n_errors = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;

  function automatic pixel_t mk_pix(logic [7:0] luma, logic [7:0] u, logic [7:0] v,
                                    logic [9:0] x, logic [9:0] y, logic ls,
                                    logic [2:0] line);
    pixel_t p;
    p.luma = luma;
    p.u    = u;
    p.v    = v;
    p.x    = x;
    p.y    = y;
    p.ls   = ls;
    p.line = line;
    return p;
  endfunction

  function automatic void add_row(pixel_t p, row_kind_e k, seg_rec_t s);
    dir_row_t r;
    r.px   = p;
    r.kind = k;
    r.seg  = s;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Advance the mirrored state by one pixel; return 1 when a run closes
  function automatic bit predict_segment(input pixel_t p, output seg_rec_t s);
    int          diff;
    int          sum;
    logic [10:0] sx;
    logic [10:0] sy;
    s = '{default: '0};
    if (p.ls) begin
      foreach (chroma_hist[i]) chroma_hist[i] = 0;
      foreach (luma_hist[i]) begin
        luma_hist[i] = '0;
        col_hist[i]  = '0;
        row_hist[i]  = '0;
      end
      fill_cnt = 0;
      run_open = 1'b0;
      run_neg  = 1'b0;
    end
    diff = int'(p.v) - int'(p.u);
    for (int i = 4; i > 0; i--) chroma_hist[i] = chroma_hist[i-1];
    chroma_hist[0] = diff;
    for (int i = 2; i > 0; i--) begin
      luma_hist[i] = luma_hist[i-1];
      col_hist[i]  = col_hist[i-1];
      row_hist[i]  = row_hist[i-1];
    end
    luma_hist[0] = p.luma;
    col_hist[0]  = p.x;
    row_hist[0]  = p.y;
    if (fill_cnt < 5) fill_cnt++;
    if (fill_cnt < 5) return 1'b0;

    sum = chroma_hist[0] + 2 * chroma_hist[1] + 4 * chroma_hist[2]
        + 2 * chroma_hist[3] + chroma_hist[4];

    // Open a run on the first passing centre; hold it while the test passes
    if (sum >= 10 * int'(cfg_thresh) && luma_hist[2] >= cfg_min_luma) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_bx   = col_hist[2];
        run_by   = row_hist[2];
        run_resp = sum;
        run_diff = diff;
        run_neg  = (diff < 0);
      end
      return 1'b0;
    end
    if (!run_open) return 1'b0;

    // Close the run at the first failing centre
    sx = {1'b0, run_bx} + {1'b0, col_hist[2]};
    sy = {1'b0, run_by} + {1'b0, row_hist[2]};
    s.line = p.line;
    s.bx   = run_bx;
    s.by   = run_by;
    s.ex   = col_hist[2];
    s.ey   = row_hist[2];
    s.mx   = sx[10:1];
    s.my   = sy[10:1];
    s.br   = 13'(run_resp);
    s.bd   = 9'(run_diff);
    s.er   = 13'(sum);
    s.ed   = 9'(diff);
    s.obst = run_neg;
    run_open = 1'b0;
    run_neg  = 1'b0;
    return 1'b1;
  endfunction

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    return burst ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Offer one pixel, wait for its transfer, then record what it should cause
  task automatic send_pixel(input pixel_t p, input row_kind_e kind, input seg_rec_t typed);
    int       gap;
    seg_rec_t s;
    bit       closes;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {1'b0, p.line, p.y, p.x, p.v, p.u, p.luma};
    s_axis_tuser_i  = p.ls;
    do @(posedge clk_i); while (!s_axis_tready_o);
    closes = predict_segment(p, s);
    case (kind)
      ROW_SEG:     pending_segments.insert(pending_segments.size(), typed);
      ROW_PREDICT: if (closes) pending_segments.insert(pending_segments.size(), s);
      default: ;
    endcase
  endtask

  // Stop offering and let every expected segment come out
  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_segments.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic addr, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = addr;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (addr == CfgGradThr) cfg_thresh = val;
    else cfg_min_luma = val;
  endtask

  // Mostly well-formed scan lines with patterned chroma, some loose pixels
  task automatic random_pixels(input int n);
    int           sent;
    int           len;
    int           region_left;
    int           i;
    chroma_mode_e mode;
    logic [7:0]   u;
    logic [7:0]   v;
    logic [7:0]   luma;
    logic [2:0]   line;
    logic [9:0]   x;
    logic [9:0]   y;
    seg_rec_t     blank;
    blank = '{default: '0};
    sent = 0;
    mode = CHROMA_FLAT;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_pixel(mk_pix(8'($urandom), 8'($urandom), 8'($urandom), 10'($urandom),
                          10'($urandom), 1'($urandom_range(0, 1)), 3'($urandom)),
                   ROW_PREDICT, blank);
        sent++;
      end else begin
        len  = int'($urandom_range(5, 40));
        line = 3'($urandom);
        x    = 10'($urandom);
        y    = 10'($urandom);
        region_left = 0;
        for (i = 0; i < len && sent < n; i++) begin
          if (region_left == 0) begin
            mode = chroma_mode_e'($urandom_range(0, 3));
            region_left = int'($urandom_range(1, 8));
          end
          region_left--;
          case (mode)
            CHROMA_HIGH: begin
              u = 8'($urandom_range(0, 60));
              v = 8'($urandom_range(180, 255));
            end
            CHROMA_LOW: begin
              u = 8'($urandom_range(180, 255));
              v = 8'($urandom_range(0, 60));
            end
            CHROMA_FLAT: begin
              u = 8'($urandom);
              v = u;
            end
            default: begin
              u = 8'($urandom);
              v = 8'($urandom);
            end
          endcase
          luma = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(cfg_min_luma, 255));
          send_pixel(mk_pix(luma, u, v, 10'(x + i), y, i == 0, line), ROW_PREDICT, blank);
          sent++;
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input int e, input int a);
    if (e != a) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
      n_errors++;
    end
  endtask

  // Stimulus
  initial begin
    seg_rec_t blank;
    seg_rec_t first_seg;
    blank = '{default: '0};
    first_seg = '{3'd7, 10'd1018, 10'd1023, 10'd1021, 10'd1023, 10'd1019, 10'd1023,
                  13'sd2550, 9'sd255, -13'sd1020, -9'sd255, 1'b0};

    // Strong positive chroma opens a run, strong negative closes it at the far corner
    add_row(mk_pix(8'd0,   8'd0,   8'd255, 10'd1016, 10'd1023, 1'b1, 3'd7), ROW_NONE, blank);
    add_row(mk_pix(8'd255, 8'd0,   8'd255, 10'd1017, 10'd1023, 1'b0, 3'd7), ROW_NONE, blank);
    add_row(mk_pix(8'd128, 8'd0,   8'd255, 10'd1018, 10'd1023, 1'b0, 3'd7), ROW_NONE, blank);
    add_row(mk_pix(8'd255, 8'd0,   8'd255, 10'd1019, 10'd1023, 1'b0, 3'd7), ROW_NONE, blank);
    add_row(mk_pix(8'd255, 8'd0,   8'd255, 10'd1020, 10'd1023, 1'b0, 3'd7), ROW_NONE, blank);
    add_row(mk_pix(8'd0,   8'd255, 8'd0,   10'd1021, 10'd1023, 1'b0, 3'd7), ROW_NONE, blank);
    add_row(mk_pix(8'd0,   8'd255, 8'd0,   10'd1022, 10'd1023, 1'b0, 3'd7), ROW_NONE, blank);
    add_row(mk_pix(8'd0,   8'd255, 8'd0,   10'd1023, 10'd1023, 1'b0, 3'd7), ROW_SEG, first_seg);
    // New line at the origin: run opens on a negative newest difference
    add_row(mk_pix(8'd0,   8'd0,   8'd255, 10'd0, 10'd0, 1'b1, 3'd0), ROW_NONE, blank);
    add_row(mk_pix(8'd0,   8'd0,   8'd255, 10'd1, 10'd0, 1'b0, 3'd0), ROW_NONE, blank);
    add_row(mk_pix(8'd0,   8'd0,   8'd255, 10'd2, 10'd0, 1'b0, 3'd0), ROW_NONE, blank);
    add_row(mk_pix(8'd0,   8'd0,   8'd255, 10'd3, 10'd0, 1'b0, 3'd0), ROW_NONE, blank);
    add_row(mk_pix(8'd0,   8'd255, 8'd0,   10'd4, 10'd0, 1'b0, 3'd0), ROW_PREDICT, blank);
    add_row(mk_pix(8'd0,   8'd255, 8'd0,   10'd5, 10'd0, 1'b0, 3'd0), ROW_PREDICT, blank);
    add_row(mk_pix(8'd0,   8'd255, 8'd0,   10'd6, 10'd0, 1'b0, 3'd0), ROW_PREDICT, blank);
    // Open a run, then drop it with a line start
    add_row(mk_pix(8'd90,  8'd10,  8'd250, 10'd100, 10'd512, 1'b1, 3'd3), ROW_PREDICT, blank);
    add_row(mk_pix(8'd91,  8'd10,  8'd250, 10'd101, 10'd512, 1'b0, 3'd3), ROW_PREDICT, blank);
    add_row(mk_pix(8'd92,  8'd10,  8'd250, 10'd102, 10'd512, 1'b0, 3'd3), ROW_PREDICT, blank);
    add_row(mk_pix(8'd93,  8'd10,  8'd250, 10'd103, 10'd512, 1'b0, 3'd3), ROW_PREDICT, blank);
    add_row(mk_pix(8'd94,  8'd10,  8'd250, 10'd104, 10'd512, 1'b0, 3'd3), ROW_PREDICT, blank);
    add_row(mk_pix(8'd0,   8'd255, 8'd0,   10'd200, 10'd511, 1'b1, 3'd4), ROW_PREDICT, blank);
    add_row(mk_pix(8'd255, 8'd255, 8'd0,   10'd201, 10'd511, 1'b0, 3'd4), ROW_PREDICT, blank);
    add_row(mk_pix(8'd0,   8'd128, 8'd128, 10'd202, 10'd511, 1'b0, 3'd4), ROW_PREDICT, blank);
    add_row(mk_pix(8'd255, 8'd255, 8'd255, 10'd203, 10'd511, 1'b0, 3'd4), ROW_PREDICT, blank);

    // Hold reset, then release between edges
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_pixel(dir_rows[i].px, dir_rows[i].kind, dir_rows[i].seg);

    // Register settings loose, then strict, then two in between, then random ones
    drain();
    write_reg(CfgGradThr, 8'd0);
    write_reg(CfgMinLuma, 8'd0);
    random_pixels(250);
    drain();
    write_reg(CfgGradThr, 8'd255);
    write_reg(CfgMinLuma, 8'd255);
    random_pixels(150);
    drain();
    write_reg(CfgGradThr, 8'd25);
    write_reg(CfgMinLuma, 8'd0);
    random_pixels(300);
    drain();
    write_reg(CfgGradThr, 8'd40);
    write_reg(CfgMinLuma, 8'd128);
    random_pixels(300);
    repeat (4) begin
      drain();
      write_reg(CfgGradThr, 8'($urandom_range(0, 60)));
      write_reg(CfgMinLuma, 8'($urandom));
      random_pixels(225);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Segment receiver: random stalls, two long hold-offs to back up the input
  initial begin
    int       n_got;
    int       gap;
    seg_rec_t exp_seg;
    seg_rec_t got;
    n_got = 0;
    @(posedge rst_ni);
    forever begin
      if (n_got == 25 || n_got == 250) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
        repeat (300) @(negedge clk_i);
      end else begin
        gap = draw_gap(recv_burst);
        if (gap > 0) begin
          @(negedge clk_i);
          m_axis_tready_i = 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
      @(negedge clk_i);
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.line = m_axis_tdata_o[2:0];
      got.bx   = m_axis_tdata_o[12:3];
      got.by   = m_axis_tdata_o[22:13];
      got.ex   = m_axis_tdata_o[32:23];
      got.ey   = m_axis_tdata_o[42:33];
      got.mx   = m_axis_tdata_o[52:43];
      got.my   = m_axis_tdata_o[62:53];
      got.br   = m_axis_tdata_o[75:63];
      got.bd   = m_axis_tdata_o[84:76];
      got.er   = m_axis_tdata_o[97:85];
      got.ed   = m_axis_tdata_o[106:98];
      got.obst = m_axis_tuser_o[0];
      n_got++;
      if (pending_segments.size() == 0) begin
        $display("%0t: unexpected segment, expected none, got begin_x %0d end_x %0d",
                 $time, got.bx, got.ex);
        n_errors++;
      end else begin
        exp_seg = pending_segments.pop_front();
        compare_field("seg_line", int'(exp_seg.line), int'(got.line));
        compare_field("begin_x", int'(exp_seg.bx), int'(got.bx));
        compare_field("begin_y", int'(exp_seg.by), int'(got.by));
        compare_field("end_x", int'(exp_seg.ex), int'(got.ex));
        compare_field("end_y", int'(exp_seg.ey), int'(got.ey));
        compare_field("mid_x", int'(exp_seg.mx), int'(got.mx));
        compare_field("mid_y", int'(exp_seg.my), int'(got.my));
        compare_field("begin_response", int'(exp_seg.br), int'(got.br));
        compare_field("begin_diff", int'(exp_seg.bd), int'(got.bd));
        compare_field("end_response", int'(exp_seg.er), int'(got.er));
        compare_field("end_diff", int'(exp_seg.ed), int'(got.ed));
        compare_field("maybe_obstacle", int'(exp_seg.obst), int'(got.obst));
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
